>>> src/twcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_pkg - shared types and helpers for the time weighted cubic spline
// Field widths, wide intermediate type, pipeline side structs, 48-bit clamp.
// ----------------------------------------------------------------------------
package twcs_pkg;

  localparam int WIDE_W = 48;
  localparam int TIME_W = 31;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 17;
  localparam int SUM_W  = WIDE_W + 4;

  typedef logic signed [WIDE_W-1:0] wide_t;

  // travels with an item through the divider stages
  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] p1;
    logic signed [VAL_W:0]   d21;
    logic signed [VAL_W:0]   s1;
    logic signed [VAL_W:0]   s2;
    logic                    nneg;
    logic [1:0]              bad;
    logic                    last;
  } front_t;

  // travels with an item through the tangent and Horner multipliers
  typedef struct packed {
    wide_t                   m1;
    wide_t                   m2;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] p1;
    logic signed [VAL_W:0]   d21;
    logic                    sat;
    logic                    bad;
    logic                    last;
  } horner_t;

  function automatic logic wide_ovf(input logic signed [SUM_W-1:0] x);
    return !((&x[SUM_W-1:WIDE_W-1]) || !(|x[SUM_W-1:WIDE_W-1]));
  endfunction

  function automatic wide_t clamp_wide(input logic signed [SUM_W-1:0] x);
    if (wide_ovf(x)) begin
      return x[SUM_W-1] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
    end
    return x[WIDE_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/twcs_mulq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twcs_mulq - pipelined fixed-point multiply
// floor(a*b / 2^FRAC_BITS) clamped to 48 bits, four stages, 24-bit partials.
// ----------------------------------------------------------------------------
module twcs_mulq #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  twcs_pkg::wide_t     a,
  input  twcs_pkg::wide_t     b,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output twcs_pkg::wide_t     prod,
  output logic                sat,
  output logic [SIDE_W-1:0]   side_out
);
  import twcs_pkg::*;

  localparam int HW = WIDE_W / 2;
  localparam int PW = 2 * WIDE_W;

  logic [3:0]                v_r;
  logic [SIDE_W-1:0]         sd_r [4];
  logic [2*HW-1:0]           ll_r, ll2_r;
  logic signed [2*HW:0]      lh_r, hl_r;
  logic signed [2*HW-1:0]    hh_r, hh2_r;
  logic signed [2*HW+1:0]    cross_r;
  logic signed [PW-1:0]      full_r;
  logic signed [PW-1:0]      sh;
  wide_t                     prod_r;
  logic                      sat_r;
  logic                      ovf;

  always_comb begin
    sh  = full_r >>> FRAC_BITS;
    ovf = !((&sh[PW-1:WIDE_W-1]) || !(|sh[PW-1:WIDE_W-1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_in;
      for (int i = 1; i < 4; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
      ll_r    <= a[HW-1:0] * b[HW-1:0];
      lh_r    <= $signed({1'b0, a[HW-1:0]}) * $signed(b[WIDE_W-1:HW]);
      hl_r    <= $signed(a[WIDE_W-1:HW]) * $signed({1'b0, b[HW-1:0]});
      hh_r    <= $signed(a[WIDE_W-1:HW]) * $signed(b[WIDE_W-1:HW]);
      cross_r <= (2*HW+2)'(lh_r) + (2*HW+2)'(hl_r);
      ll2_r   <= ll_r;
      hh2_r   <= hh_r;
      full_r  <= (PW'(hh2_r) <<< (2*HW)) + (PW'(cross_r) <<< HW) + $signed(PW'(ll2_r));
      if (ovf) begin
        prod_r <= sh[PW-1] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
      end else begin
        prod_r <= sh[WIDE_W-1:0];
      end
      sat_r <= ovf;
    end
  end

  assign out_valid = v_r[3];
  assign prod      = prod_r;
  assign sat       = sat_r;
  assign side_out  = sd_r[3];

endmodule
`default_nettype wire

>>> src/time_weighted_cubic_spline.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_weighted_cubic_spline - nonuniform Hermite spline, one component/item
// Time-ratio tangents by two pipelined dividers, Horner evaluation by
// pipelined multipliers, 48-bit clamped intermediates, 32-bit saturation.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; one quotient bit per divider stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module time_weighted_cubic_spline #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [twcs_pkg::POS_W-1:0]         in_interp_pos,
  input  logic [twcs_pkg::TIME_W-1:0]        in_key_time_0,
  input  logic [twcs_pkg::TIME_W-1:0]        in_key_time_1,
  input  logic [twcs_pkg::TIME_W-1:0]        in_key_time_2,
  input  logic [twcs_pkg::TIME_W-1:0]        in_key_time_3,
  input  logic signed [twcs_pkg::VAL_W-1:0]  in_ctrl_point_0,
  input  logic signed [twcs_pkg::VAL_W-1:0]  in_ctrl_point_1,
  input  logic signed [twcs_pkg::VAL_W-1:0]  in_ctrl_point_2,
  input  logic signed [twcs_pkg::VAL_W-1:0]  in_ctrl_point_3,
  input  logic        in_last_component,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [twcs_pkg::VAL_W-1:0]  out_spline_value,
  output logic        out_saturated,
  output logic        out_bad_timing,
  output logic        out_last_out
);
  import twcs_pkg::*;

  localparam int NW  = TIME_W + FRAC_BITS;
  localparam int HSW = $bits(horner_t);
  localparam logic [63:0] QMAX_POS = (64'd1 << (WIDE_W-1)) - 64'd1;
  localparam logic [63:0] QMAX_NEG = (64'd1 << (WIDE_W-1));

  logic en;
  logic accept;

  // ---------------- input stage ----------------
  logic signed [TIME_W:0]  num, den0, den1;
  logic [TIME_W-1:0]       nmag;
  front_t                  fr_in;

  always_comb begin
    num  = $signed({1'b0, in_key_time_2}) - $signed({1'b0, in_key_time_1});
    den0 = $signed({1'b0, in_key_time_2}) - $signed({1'b0, in_key_time_0});
    den1 = $signed({1'b0, in_key_time_3}) - $signed({1'b0, in_key_time_1});
    nmag = num[TIME_W] ? TIME_W'(-num) : num[TIME_W-1:0];
    fr_in.pos    = in_interp_pos;
    fr_in.p1     = in_ctrl_point_1;
    fr_in.d21    = (VAL_W+1)'(in_ctrl_point_2) - (VAL_W+1)'(in_ctrl_point_1);
    fr_in.s1     = (VAL_W+1)'(in_ctrl_point_2) - (VAL_W+1)'(in_ctrl_point_0);
    fr_in.s2     = (VAL_W+1)'(in_ctrl_point_3) - (VAL_W+1)'(in_ctrl_point_1);
    fr_in.nneg   = num[TIME_W];
    fr_in.bad[0] = den0[TIME_W] || (den0 == '0);
    fr_in.bad[1] = den1[TIME_W] || (den1 == '0);
    fr_in.last   = in_last_component;
  end

  // ---------------- divider stages ----------------
  logic                vd_r  [NW+1];
  front_t              fr_r  [NW+1];
  logic [TIME_W-1:0]   rem_r [2][NW+1];
  logic [TIME_W-1:0]   den_r [2][NW+1];
  logic [NW-1:0]       nq_r  [2][NW+1];
  logic [TIME_W+1:0]   diff     [2][NW];
  logic [TIME_W-1:0]   rem_nxt  [2][NW];
  logic [NW-1:0]       nq_nxt   [2][NW];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < NW; i++) begin
        diff[l][i] = {1'b0, rem_r[l][i], nq_r[l][i][NW-1]} - {2'b00, den_r[l][i]};
        if (!diff[l][i][TIME_W+1]) begin
          rem_nxt[l][i] = diff[l][i][TIME_W-1:0];
        end else begin
          rem_nxt[l][i] = {rem_r[l][i][TIME_W-2:0], nq_r[l][i][NW-1]};
        end
        nq_nxt[l][i] = {nq_r[l][i][NW-2:0], !diff[l][i][TIME_W+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NW; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= accept;
      for (int i = 1; i <= NW; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r[0]     <= fr_in;
      rem_r[0][0] <= '0;
      rem_r[1][0] <= '0;
      den_r[0][0] <= den0[TIME_W-1:0];
      den_r[1][0] <= den1[TIME_W-1:0];
      nq_r[0][0]  <= {nmag, {FRAC_BITS{1'b0}}};
      nq_r[1][0]  <= {nmag, {FRAC_BITS{1'b0}}};
      for (int i = 0; i < NW; i++) begin
        fr_r[i+1] <= fr_r[i];
        for (int l = 0; l < 2; l++) begin
          rem_r[l][i+1] <= rem_nxt[l][i];
          den_r[l][i+1] <= den_r[l][i];
          nq_r[l][i+1]  <= nq_nxt[l][i];
        end
      end
    end
  end

  // ---------------- scale finish ----------------
  logic [63:0] qx   [2];
  wide_t       sc_nxt [2];
  logic [1:0]  scs_nxt;
  front_t      frd;

  always_comb begin
    frd = fr_r[NW];
    for (int l = 0; l < 2; l++) begin
      qx[l] = 64'(nq_r[l][NW]);
      scs_nxt[l] = 1'b0;
      if (frd.bad[l]) begin
        sc_nxt[l] = '0;
      end else if (!frd.nneg && (qx[l] > QMAX_POS)) begin
        sc_nxt[l]  = {1'b0, {(WIDE_W-1){1'b1}}};
        scs_nxt[l] = 1'b1;
      end else if (frd.nneg && (qx[l] > QMAX_NEG)) begin
        sc_nxt[l]  = {1'b1, {(WIDE_W-1){1'b0}}};
        scs_nxt[l] = 1'b1;
      end else if (frd.nneg) begin
        sc_nxt[l] = WIDE_W'(-qx[l]);
      end else begin
        sc_nxt[l] = qx[l][WIDE_W-1:0];
      end
    end
  end

  logic        sc_v_r;
  wide_t       so_r, si_r;
  logic [1:0]  scs_r;
  front_t      sc_fr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else if (en) begin
      sc_v_r <= vd_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_r    <= sc_nxt[0];
      si_r    <= sc_nxt[1];
      scs_r   <= scs_nxt;
      sc_fr_r <= frd;
    end
  end

  // ---------------- tangents ----------------
  horner_t  t_side;
  logic     m1_v, m2_v, m1_s, m2_s;
  wide_t    m1_p, m2_p;
  logic [HSW-1:0] t_side_out;
  logic     m2_side_out;
  horner_t  t_h;

  always_comb begin
    t_side.m1   = '0;
    t_side.m2   = '0;
    t_side.pos  = sc_fr_r.pos;
    t_side.p1   = sc_fr_r.p1;
    t_side.d21  = sc_fr_r.d21;
    t_side.sat  = scs_r[0];
    t_side.bad  = |sc_fr_r.bad;
    t_side.last = sc_fr_r.last;
  end

  twcs_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(HSW)) u_mul_m1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sc_v_r),
    .a(so_r), .b(WIDE_W'(sc_fr_r.s1)), .side_in(t_side),
    .out_valid(m1_v), .prod(m1_p), .sat(m1_s), .side_out(t_side_out)
  );

  twcs_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_m2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sc_v_r),
    .a(si_r), .b(WIDE_W'(sc_fr_r.s2)), .side_in(scs_r[1]),
    .out_valid(m2_v), .prod(m2_p), .sat(m2_s), .side_out(m2_side_out)
  );

  // ---------------- Horner step 0: -2*d21 + m1 + m2 ----------------
  logic signed [SUM_W-1:0] sum0;
  logic     h0_v_r;
  wide_t    h0_r;
  horner_t  h0_side_r;
  horner_t  h0_side_nxt;

  always_comb begin
    t_h  = horner_t'(t_side_out);
    sum0 = SUM_W'(m1_p) + SUM_W'(m2_p) - (SUM_W'(t_h.d21) <<< 1);
    h0_side_nxt     = t_h;
    h0_side_nxt.m1  = m1_p;
    h0_side_nxt.m2  = m2_p;
    h0_side_nxt.sat = t_h.sat | m2_side_out | m1_s | m2_s | wide_ovf(sum0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_v_r <= 1'b0;
    end else if (en) begin
      h0_v_r <= m1_v && m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0_r      <= clamp_wide(sum0);
      h0_side_r <= h0_side_nxt;
    end
  end

  logic           ma_v, ma_s;
  wide_t          ma_p;
  logic [HSW-1:0] ma_side;
  horner_t        ha;

  twcs_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(HSW)) u_mul_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h0_v_r),
    .a(h0_r), .b($signed(WIDE_W'(h0_side_r.pos))), .side_in(h0_side_r),
    .out_valid(ma_v), .prod(ma_p), .sat(ma_s), .side_out(ma_side)
  );

  // ---------------- Horner step 1: r*t - m2 - 2*m1 + 3*d21 ----------------
  logic signed [SUM_W-1:0] sum1;
  logic     h1_v_r;
  wide_t    h1_r;
  horner_t  h1_side_r;
  horner_t  h1_side_nxt;

  always_comb begin
    ha   = horner_t'(ma_side);
    sum1 = SUM_W'(ma_p) - SUM_W'(ha.m2) - (SUM_W'(ha.m1) <<< 1)
         + (SUM_W'(ha.d21) <<< 1) + SUM_W'(ha.d21);
    h1_side_nxt     = ha;
    h1_side_nxt.sat = ha.sat | ma_s | wide_ovf(sum1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_v_r <= 1'b0;
    end else if (en) begin
      h1_v_r <= ma_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r      <= clamp_wide(sum1);
      h1_side_r <= h1_side_nxt;
    end
  end

  logic           mb_v, mb_s;
  wide_t          mb_p;
  logic [HSW-1:0] mb_side;
  horner_t        hb;

  twcs_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(HSW)) u_mul_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h1_v_r),
    .a(h1_r), .b($signed(WIDE_W'(h1_side_r.pos))), .side_in(h1_side_r),
    .out_valid(mb_v), .prod(mb_p), .sat(mb_s), .side_out(mb_side)
  );

  // ---------------- Horner step 2: r*t + m1 ----------------
  logic signed [SUM_W-1:0] sum2;
  logic     h2_v_r;
  wide_t    h2_r;
  horner_t  h2_side_r;
  horner_t  h2_side_nxt;

  always_comb begin
    hb   = horner_t'(mb_side);
    sum2 = SUM_W'(mb_p) + SUM_W'(hb.m1);
    h2_side_nxt     = hb;
    h2_side_nxt.sat = hb.sat | mb_s | wide_ovf(sum2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_v_r <= 1'b0;
    end else if (en) begin
      h2_v_r <= mb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_r      <= clamp_wide(sum2);
      h2_side_r <= h2_side_nxt;
    end
  end

  logic           mc_v, mc_s;
  wide_t          mc_p;
  logic [HSW-1:0] mc_side;
  horner_t        hc;

  twcs_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(HSW)) u_mul_c (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h2_v_r),
    .a(h2_r), .b($signed(WIDE_W'(h2_side_r.pos))), .side_in(h2_side_r),
    .out_valid(mc_v), .prod(mc_p), .sat(mc_s), .side_out(mc_side)
  );

  // ---------------- final add and 32-bit saturation ----------------
  logic signed [WIDE_W:0]  fin;
  logic                    fin_ovf;
  logic signed [VAL_W-1:0] fin_val;

  always_comb begin
    hc      = horner_t'(mc_side);
    fin     = (WIDE_W+1)'(mc_p) + (WIDE_W+1)'(hc.p1);
    fin_ovf = !((&fin[WIDE_W:VAL_W-1]) || !(|fin[WIDE_W:VAL_W-1]));
    if (fin_ovf) begin
      fin_val = fin[WIDE_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      fin_val = fin[VAL_W-1:0];
    end
  end

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_sat_r, out_bad_r, out_last_r;

  // hold everything while a finished item waits downstream
  assign en     = !out_valid_r || !out_stall;
  assign accept = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r  <= fin_val;
      out_sat_r  <= hc.sat | mc_s | fin_ovf;
      out_bad_r  <= hc.bad;
      out_last_r <= hc.last;
    end
  end

  assign in_stall         = !en;
  assign out_valid        = out_valid_r;
  assign out_spline_value = out_val_r;
  assign out_saturated    = out_sat_r;
  assign out_bad_timing   = out_bad_r;
  assign out_last_out     = out_last_r;

  // ---------------- assertions ----------------
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output item is held");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_mul_align: assert property (@(posedge clk) disable iff (!rst_n)
    m1_v == m2_v)
    else $error("tangent multipliers out of step");

endmodule
`default_nettype wire

>>> tb/time_weighted_cubic_spline_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_weighted_cubic_spline_tb - self-checking bench for the spline block
// Drives directed and random components through the valid/stall ports,
// predicts each value with a behavioral fixed-point model and compares the
// results in order, under random idling on both sides and one long hold-off.
// ----------------------------------------------------------------------------
module time_weighted_cubic_spline_tb;
  import twcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [POS_W-1:0]        pos;
    logic [TIME_W-1:0]       k0, k1, k2, k3;
    logic signed [VAL_W-1:0] p0, p1, p2, p3;
    logic                    last;
  } component_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic sat, bad, last;
  } spline_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_W-1:0] in_interp_pos = '0;
  logic [TIME_W-1:0] in_key_time_0 = '0, in_key_time_1 = '0;
  logic [TIME_W-1:0] in_key_time_2 = '0, in_key_time_3 = '0;
  logic signed [VAL_W-1:0] in_ctrl_point_0 = '0, in_ctrl_point_1 = '0;
  logic signed [VAL_W-1:0] in_ctrl_point_2 = '0, in_ctrl_point_3 = '0;
  logic in_last_component = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_spline_value;
  logic out_saturated, out_bad_timing, out_last_out;

  time_weighted_cubic_spline #(.FRAC_BITS(FB)) DUT (.*);

  component_t  pending_items[$];
  spline_res_t expected_values[$];
  int errors = 0;
  int cycles = 0;
  int idle_mode = 0;      // 0: sender idles more rarely, 1: swapped, 2: none
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------
  bit sat_seen;

  function automatic longint clamp48(longint x);
    longint hi, lo;
    hi = (64'sd1 <<< 47) - 1;
    lo = -(64'sd1 <<< 47);
    if (x > hi) begin sat_seen = 1; return hi; end
    if (x < lo) begin sat_seen = 1; return lo; end
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] prod;
    logic signed [127:0] q;
    prod = 128'(signed'(a)) * 128'(signed'(b));
    q = prod >>> FB;                         // floor
    if (q > 128'sd140737488355327) begin sat_seen = 1; return (64'sd1 <<< 47) - 1; end
    if (q < -128'sd140737488355328) begin sat_seen = 1; return -(64'sd1 <<< 47); end
    return longint'(q);
  endfunction

  function automatic longint tscale(longint num, longint den, inout bit bad);
    if (den <= 0) begin bad = 1; return 0; end
    return clamp48((num * (64'sd1 <<< FB)) / den);
  endfunction

  function automatic spline_res_t spline_eval(component_t c);
    spline_res_t res;
    longint t, d10, d21, d32, so, si, m1, m2, r;
    bit bad;
    bad = 0;
    sat_seen = 0;
    t = c.pos;
    d10 = longint'(c.p1) - longint'(c.p0);
    d21 = longint'(c.p2) - longint'(c.p1);
    d32 = longint'(c.p3) - longint'(c.p2);
    so = tscale(longint'(c.k2) - longint'(c.k1), longint'(c.k2) - longint'(c.k0), bad);
    si = tscale(longint'(c.k2) - longint'(c.k1), longint'(c.k3) - longint'(c.k1), bad);
    m1 = qmul(so, d10 + d21);
    m2 = qmul(si, d21 + d32);
    r = clamp48(-2 * d21 + m1 + m2);
    r = qmul(r, t);
    r = clamp48(r - m2 - 2 * m1 + 3 * d21);
    r = qmul(r, t);
    r = clamp48(r + m1);
    r = qmul(r, t);
    r = r + longint'(c.p1);
    if (r > 64'sd2147483647) begin r = 64'sd2147483647; sat_seen = 1; end
    if (r < -64'sd2147483648) begin r = -64'sd2147483648; sat_seen = 1; end
    res.value = r[31:0];
    res.sat = sat_seen;
    res.bad = bad;
    res.last = c.last;
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] rnd_val(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic component_t rnd_component();
    component_t c;
    logic [30:0] base;
    int vm;
    vm = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
    c.pos = $urandom_range(0, 19) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, 65536));
    if ($urandom_range(0, 9) < 7) begin
      // ordered keys, small gaps
      base = TIME_W'($urandom_range(0, 1 << 30));
      c.k0 = base;
      c.k1 = c.k0 + TIME_W'($urandom_range(1, 2000));
      c.k2 = c.k1 + TIME_W'($urandom_range(1, 2000));
      c.k3 = c.k2 + TIME_W'($urandom_range(1, 2000));
    end else begin
      c.k0 = TIME_W'($urandom); c.k1 = TIME_W'($urandom);
      c.k2 = TIME_W'($urandom); c.k3 = TIME_W'($urandom);
      if ($urandom_range(0, 3) == 0) c.k2 = c.k0;
    end
    c.p0 = rnd_val(vm); c.p1 = rnd_val(vm); c.p2 = rnd_val(vm); c.p3 = rnd_val(vm);
    c.last = $urandom_range(0, 3) == 0;
    return c;
  endfunction

  function automatic component_t mk(int pos, int k0, int k1, int k2, int k3,
                                    int p0, int p1, int p2, int p3, bit last);
    component_t c;
    c.pos = POS_W'(pos);
    c.k0 = TIME_W'(k0); c.k1 = TIME_W'(k1); c.k2 = TIME_W'(k2); c.k3 = TIME_W'(k3);
    c.p0 = p0; c.p1 = p1; c.p2 = p2; c.p3 = p3; c.last = last;
    return c;
  endfunction

  initial begin
    int n;
    // plain segment, endpoints and midpoint
    pending_items.push_back(mk(0, 0, 100, 200, 300, 0, 65536, 131072, 196608, 0));
    pending_items.push_back(mk(65536, 0, 100, 200, 300, 0, 65536, 131072, 196608, 1));
    pending_items.push_back(mk(32768, 0, 100, 300, 350, -65536, 0, 65536, -65536, 0));
    // bad denominators, each and both
    pending_items.push_back(mk(32768, 200, 100, 200, 300, 1, 2, 3, 4, 0));
    pending_items.push_back(mk(32768, 0, 300, 200, 300, 5, 6, 7, 8, 1));
    pending_items.push_back(mk(16384, 500, 400, 100, 50, 100, -100, 100, -100, 0));
    // extrapolation with maximal position
    pending_items.push_back(mk(131071, 0, 100, 200, 300, 0, 65536, 131072, 196608, 0));
    pending_items.push_back(mk(131071, 0, 1, 2, 3, 32'h80000000, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff, 1));
    // full-range key times: unit and huge time ratio
    pending_items.push_back(mk(32768, 0, 0, 31'h7fffffff, 31'h7fffffff, 0, 10, 20, 30, 0));
    pending_items.push_back(mk(65535, 31'h7ffffffe, 0, 31'h7fffffff, 1, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff, 32'h80000000, 1));
    // extremes of key times and values
    pending_items.push_back(mk(0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                               -1, -1, -1, -1, 0));
    pending_items.push_back(mk(1, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 1));
    pending_items.push_back(mk(65536, 0, 1, 2, 31'h7fffffff, 32'h80000000, 0, 32'h7fffffff,
                               0, 0));
    for (n = 0; n < 750; n++) pending_items.push_back(rnd_component());
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    component_t c;
    bit offer;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) expected_values.push_back(spline_eval(pending_items.pop_front()));
        case (idle_mode)
          0: offer = $urandom_range(0, 99) >= 7;
          1: offer = $urandom_range(0, 99) >= 82;
          default: offer = 1;
        endcase
        if (pending_items.size() > 0 && offer) begin
          c = pending_items[0];
          in_valid <= 1'b1;
          in_interp_pos <= c.pos;
          in_key_time_0 <= c.k0; in_key_time_1 <= c.k1;
          in_key_time_2 <= c.k2; in_key_time_3 <= c.k3;
          in_ctrl_point_0 <= c.p0; in_ctrl_point_1 <= c.p1;
          in_ctrl_point_2 <= c.p2; in_ctrl_point_3 <= c.p3;
          in_last_component <= c.last;
        end else begin
          in_valid <= 1'b0;
          if (pending_items.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // ---------------- receiver stall ----------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (rst_n && !hold_done && pending_items.size() <= 600) begin
      hold_cycles <= 300;   // long hold-off so the pipeline backs up
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      case (idle_mode)
        0: out_stall <= $urandom_range(0, 99) < 82;
        1: out_stall <= $urandom_range(0, 99) < 7;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    spline_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected result", out_spline_value, 0);
      end else begin
        e = expected_values.pop_front();
        if (out_spline_value !== e.value) report_mismatch("value", out_spline_value, e.value);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        if (out_bad_timing !== e.bad) report_mismatch("bad_timing", out_bad_timing, e.bad);
        if (out_last_out !== e.last) report_mismatch("last", out_last_out, e.last);
      end
    end
  end

  // ---------------- sequencing ----------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() < 500);
    idle_mode = 1;
    wait (pending_items.size() < 250);
    idle_mode = 2;
    wait (stim_done && expected_values.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("time_weighted_cubic_spline_tb: done, clean");
    end else begin
      $display("time_weighted_cubic_spline_tb: done, errors");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("cycle limit reached");
    $display("time_weighted_cubic_spline_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
